@@ src/hsl_pkg.sv @@
// Shared types, constants and the arctangent table of the heading slew limiter.
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int POS_W  = 32;
  localparam int DIFF_W = 33;
  localparam int YAW_W  = 15;
  localparam int CMD_W  = 16;
  localparam int STEP_W = 14;
  localparam int THR_W  = 31;
  localparam int XW     = 51;
  localparam int ZW     = 19;
  localparam int ALW    = 13;
  localparam int GW     = 18;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd1;

  localparam logic [STEP_W-1:0] MAX_YAW_STEP_RST   = 14'd614;
  localparam logic [THR_W-1:0]  NEAR_THRESHOLD_RST = 31'd19661;

  localparam logic signed [GW-1:0] Q12_PI      = 18'sd12868;
  localparam logic signed [GW-1:0] Q12_TWO_PI  = 18'sd25736;
  localparam logic [ALW-1:0]       Q12_HALF_PI = 13'd6434;
  localparam logic [ZW-1:0]        Z_ROUND     = 19'd8;

  typedef struct packed {
    logic               dx_neg;
    logic               dy_neg;
    logic               dx_zero;
    logic               dy_zero;
    logic               near;
    logic [YAW_W-1:0]   yaw;
  } side_t;

  typedef struct packed {
    logic                    valid;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    side_t                   side;
  } cell_bus_t;

  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
    logic [ZW-1:0] a;
    case (i)
      5'd0:    a = 19'd51472;
      5'd1:    a = 19'd30386;
      5'd2:    a = 19'd16055;
      5'd3:    a = 19'd8150;
      5'd4:    a = 19'd4091;
      5'd5:    a = 19'd2047;
      5'd6:    a = 19'd1024;
      5'd7:    a = 19'd512;
      5'd8:    a = 19'd256;
      5'd9:    a = 19'd128;
      5'd10:   a = 19'd64;
      5'd11:   a = 19'd32;
      5'd12:   a = 19'd16;
      5'd13:   a = 19'd8;
      5'd14:   a = 19'd4;
      5'd15:   a = 19'd2;
      5'd16:   a = 19'd1;
      default: a = 19'd0;
    endcase
    return a;
  endfunction

endpackage

@@ src/hsl_front.sv @@
// Offset, magnitude and proximity stages feeding the first CORDIC cell.
`timescale 1ns / 1ps
module hsl_front
  import hsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [POS_W-1:0] in_current_x,
  input  logic signed [POS_W-1:0] in_current_y,
  input  logic signed [POS_W-1:0] in_target_x,
  input  logic signed [POS_W-1:0] in_target_y,
  input  logic signed [YAW_W-1:0] in_current_yaw,
  input  logic [THR_W-1:0]        near_threshold,
  output cell_bus_t               bus_o
);

  logic                     v1_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic [YAW_W-1:0]         yaw1_r;
  logic signed [DIFF_W-1:0] dx_nxt;
  logic signed [DIFF_W-1:0] dy_nxt;
  logic [DIFF_W-1:0]        adx;
  logic [DIFF_W-1:0]        ady;
  cell_bus_t                bus_r;
  cell_bus_t                bus_nxt;

  assign dx_nxt = {in_target_x[POS_W-1], in_target_x} - {in_current_x[POS_W-1], in_current_x};
  assign dy_nxt = {in_target_y[POS_W-1], in_target_y} - {in_current_y[POS_W-1], in_current_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      yaw1_r <= in_current_yaw;
    end
  end

  always_comb begin
    adx = dx_r[DIFF_W-1] ? -dx_r : dx_r;
    ady = dy_r[DIFF_W-1] ? -dy_r : dy_r;
    bus_nxt              = '0;
    bus_nxt.valid        = v1_r;
    bus_nxt.x            = {{(XW-DIFF_W-16){1'b0}}, adx, 16'b0};
    bus_nxt.y            = {{(XW-DIFF_W-16){1'b0}}, ady, 16'b0};
    bus_nxt.z            = '0;
    bus_nxt.side.dx_neg  = dx_r[DIFF_W-1];
    bus_nxt.side.dy_neg  = dy_r[DIFF_W-1];
    bus_nxt.side.dx_zero = (dx_r == '0);
    bus_nxt.side.dy_zero = (dy_r == '0);
    bus_nxt.side.near    = (adx < {2'b0, near_threshold}) && (ady < {2'b0, near_threshold});
    bus_nxt.side.yaw     = yaw1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (adv) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

@@ src/hsl_cordic_cell.sv @@
// One vectoring CORDIC cell: a fixed shift, a rotation step and its register.
`timescale 1ns / 1ps
module hsl_cordic_cell
  import hsl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  cell_bus_t bus_i,
  output cell_bus_t bus_o
);

  logic [XW-1:0] xs;
  logic [XW-1:0] y_mag;
  logic [XW-1:0] y_sh;
  logic [XW-1:0] ys;
  logic [ZW-1:0] a;
  cell_bus_t     bus_r;
  cell_bus_t     bus_nxt;

  assign a = atan_q16(5'(IDX));

  always_comb begin
    xs    = bus_i.x >> IDX;
    y_mag = bus_i.y[XW-1] ? -bus_i.y : bus_i.y;
    y_sh  = y_mag >> IDX;
    ys    = bus_i.y[XW-1] ? -y_sh : y_sh;
    bus_nxt = bus_i;
    if (!bus_i.y[XW-1]) begin
      bus_nxt.x = bus_i.x + ys;
      bus_nxt.y = bus_i.y - xs;
      bus_nxt.z = bus_i.z + a;
    end else begin
      bus_nxt.x = bus_i.x - ys;
      bus_nxt.y = bus_i.y + xs;
      bus_nxt.z = bus_i.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (adv) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

@@ src/hsl_post.sv @@
// Heading assembly, unwrapping, slew limiting and the result register.
`timescale 1ns / 1ps
module hsl_post
  import hsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  cell_bus_t               bus_i,
  input  logic [STEP_W-1:0]       max_yaw_step,
  output logic                    out_valid,
  output logic signed [CMD_W-1:0] out_yaw_command,
  output logic signed [YAW_W-1:0] out_target_heading,
  output logic                    out_near_target
);

  logic                    v_r;
  logic signed [YAW_W-1:0] heading_r;
  logic signed [YAW_W-1:0] heading_nxt;
  logic [YAW_W-1:0]        yaw_r;
  logic                    near_r;
  logic                    ov_r;
  logic signed [CMD_W-1:0] cmd_r;
  logic signed [CMD_W-1:0] cmd_nxt;
  logic signed [YAW_W-1:0] head_out_r;
  logic                    near_out_r;

  logic signed [ZW-1:0]    zr;
  logic [ZW-5:0]           zt;
  logic [ALW-1:0]          alpha;
  logic signed [GW-1:0]    a_ext;
  logic signed [GW-1:0]    h_ext;
  logic signed [GW-1:0]    yaw_ext;
  logic signed [GW-1:0]    step_ext;
  logic signed [GW-1:0]    diff;
  logic signed [GW-1:0]    goal;
  logic signed [GW-1:0]    d2;
  logic signed [GW-1:0]    cmd_w;

  always_comb begin
    zr = bus_i.z + Z_ROUND;
    zt = zr[ZW-1:4];
    if (zr[ZW-1]) begin
      alpha = '0;
    end else if (zt > {2'b0, Q12_HALF_PI}) begin
      alpha = Q12_HALF_PI;
    end else begin
      alpha = zt[ALW-1:0];
    end
    if (bus_i.side.dy_zero) begin
      a_ext = '0;
    end else if (bus_i.side.dx_zero) begin
      a_ext = {{(GW-ALW){1'b0}}, Q12_HALF_PI};
    end else begin
      a_ext = {{(GW-ALW){1'b0}}, alpha};
    end
    if (bus_i.side.dx_neg) begin
      h_ext = bus_i.side.dy_neg ? (a_ext - Q12_PI) : (Q12_PI - a_ext);
    end else begin
      h_ext = bus_i.side.dy_neg ? -a_ext : a_ext;
    end
    heading_nxt = h_ext[YAW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= bus_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= heading_nxt;
      yaw_r     <= bus_i.side.yaw;
      near_r    <= bus_i.side.near;
    end
  end

  always_comb begin
    yaw_ext  = {{(GW-YAW_W){yaw_r[YAW_W-1]}}, yaw_r};
    step_ext = {{(GW-STEP_W){1'b0}}, max_yaw_step};
    diff     = yaw_ext - {{(GW-YAW_W){heading_r[YAW_W-1]}}, heading_r};
    if (diff >= Q12_PI) begin
      goal = {{(GW-YAW_W){heading_r[YAW_W-1]}}, heading_r} + Q12_TWO_PI;
    end else if (diff <= -Q12_PI) begin
      goal = {{(GW-YAW_W){heading_r[YAW_W-1]}}, heading_r} - Q12_TWO_PI;
    end else begin
      goal = {{(GW-YAW_W){heading_r[YAW_W-1]}}, heading_r};
    end
    d2 = yaw_ext - goal;
    if (goal <= yaw_ext) begin
      cmd_w = (d2 > step_ext) ? (yaw_ext - step_ext) : goal;
    end else begin
      cmd_w = (-d2 > step_ext) ? (yaw_ext + step_ext) : goal;
    end
    if (near_r) begin
      cmd_w = yaw_ext;
    end
    if (cmd_w > 18'sd32767) begin
      cmd_nxt = 16'sh7FFF;
    end else if (cmd_w < -18'sd32768) begin
      cmd_nxt = 16'sh8000;
    end else begin
      cmd_nxt = cmd_w[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r      <= cmd_nxt;
      head_out_r <= heading_r;
      near_out_r <= near_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_yaw_command    = cmd_r;
  assign out_target_heading = head_out_r;
  assign out_near_target    = near_out_r;

endmodule

@@ src/heading_slew_limiter_top.sv @@
// Path: the hsl_front registers, each CORDIC cell's register, the hsl_post registers.
// Throughput: one transaction per cycle; the whole row of cells advances together
// and halts only while a finished result sits in the output register under out_stall.
// Reset (synchronous, rst_n low): all valid bits clear, max_yaw_step = 614,
// near_threshold = 19661.
`timescale 1ns / 1ps
module heading_slew_limiter_top
  import hsl_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [POS_W-1:0]  in_current_x,
  input  logic signed [POS_W-1:0]  in_current_y,
  input  logic signed [POS_W-1:0]  in_target_x,
  input  logic signed [POS_W-1:0]  in_target_y,
  input  logic signed [YAW_W-1:0]  in_current_yaw,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CMD_W-1:0]  out_yaw_command,
  output logic signed [YAW_W-1:0]  out_target_heading,
  output logic                     out_near_target,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  logic [STEP_W-1:0] max_yaw_step_r;
  logic [THR_W-1:0]  near_threshold_r;
  logic              adv;
  cell_bus_t         bus [CORDIC_STAGES+1];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign adv       = ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_yaw_step_r   <= MAX_YAW_STEP_RST;
      near_threshold_r <= NEAR_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_YAW_STEP:   max_yaw_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_NEAR_THRESHOLD: near_threshold_r <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hsl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_current_x   (in_current_x),
    .in_current_y   (in_current_y),
    .in_target_x    (in_target_x),
    .in_target_y    (in_target_y),
    .in_current_yaw (in_current_yaw),
    .near_threshold (near_threshold_r),
    .bus_o          (bus[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    hsl_cordic_cell #(
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .bus_i (bus[k]),
      .bus_o (bus[k+1])
    );
  end

  hsl_post u_post (
    .clk                (clk),
    .rst_n              (rst_n),
    .adv                (adv),
    .bus_i              (bus[CORDIC_STAGES]),
    .max_yaw_step       (max_yaw_step_r),
    .out_valid          (out_valid),
    .out_yaw_command    (out_yaw_command),
    .out_target_heading (out_target_heading),
    .out_near_target    (out_near_target)
  );

endmodule

@@ src/hsl_checker.sv @@
// Port-level assertions for the heading slew limiter and their bind.
`timescale 1ns / 1ps
module hsl_checker
  import hsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_stall,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [CMD_W-1:0]  out_yaw_command,
  input  logic signed [YAW_W-1:0]  out_target_heading,
  input  logic                     out_near_target
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high straight after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not blocked");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_heading >= -15'sd12868 && out_target_heading <= 15'sd12868))
    else $error("target heading outside -pi..pi");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_yaw_command)
      && $stable(out_target_heading) && $stable(out_near_target)))
    else $error("stalled result transaction changed");

endmodule

bind heading_slew_limiter_top hsl_checker u_hsl_checker (.*);

@@ tb/heading_slew_limiter_top_test.sv @@
// Self-checking testbench for heading_slew_limiter_top: directed pose table, then random poses.
`timescale 1ns / 1ps
module heading_slew_limiter_top_test;
  import hsl_pkg::*;

  localparam int CORDIC_STAGES   = 16;
  localparam int PIPE_LATENCY    = CORDIC_STAGES + 4;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int TIMEOUT_NS      = 2_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam longint POS_MIN = -(longint'(1) <<< 31);
  localparam longint POS_MAX = (longint'(1) <<< 31) - 1;

  localparam int ATAN_LUT [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [YAW_W-1:0] yaw;
  } pose_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd;
    logic signed [YAW_W-1:0] heading;
    logic                    near;
  } steer_t;

  typedef struct packed {
    pose_t  pose;
    logic   typed;
    steer_t want;
  } vec_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_current_x;
  logic signed [POS_W-1:0] in_current_y;
  logic signed [POS_W-1:0] in_target_x;
  logic signed [POS_W-1:0] in_target_y;
  logic signed [YAW_W-1:0] in_current_yaw;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [CMD_W-1:0] out_yaw_command;
  logic signed [YAW_W-1:0] out_target_heading;
  logic                    out_near_target;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  logic [STEP_W-1:0] yaw_step_q = MAX_YAW_STEP_RST;
  logic [THR_W-1:0]  near_thr_q = NEAR_THRESHOLD_RST;

  steer_t expected_steer [$];
  vec_t   directed_rows [$];
  int     n_errors = 0;
  int     burst_left = 0;
  bit     gaps_on = 1'b1;
  int     stall_mode = 0;
  int     stall_hold = 0;

  heading_slew_limiter_top #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_current_x      (in_current_x),
    .in_current_y      (in_current_y),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .in_current_yaw    (in_current_yaw),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_yaw_command   (out_yaw_command),
    .out_target_heading(out_target_heading),
    .out_near_target   (out_near_target),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint trunc_shift(input longint v, input int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint quadrant_angle(input longint ax, input longint ay);
    longint x, y, z, xs, ys, a;
    x = ax * 65536;
    y = ay * 65536;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = trunc_shift(x, i);
      ys = trunc_shift(y, i);
      a  = (i <= 16) ? longint'(ATAN_LUT[i]) : 0;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + a;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - a;
      end
    end
    z = trunc_shift(z + 8, 4);
    if (z < 0) z = 0;
    if (z > longint'(Q12_HALF_PI)) z = longint'(Q12_HALF_PI);
    return z;
  endfunction

  function automatic steer_t steer_for(input pose_t p);
    longint dx, dy, adx, ady, alpha, heading, goal, cmd, yaw, step, pi_q, two_pi_q;
    bit     near;
    steer_t r;
    pi_q     = longint'(Q12_PI);
    two_pi_q = longint'(Q12_TWO_PI);
    dx   = longint'($signed(p.tx)) - longint'($signed(p.cx));
    dy   = longint'($signed(p.ty)) - longint'($signed(p.cy));
    yaw  = longint'($signed(p.yaw));
    step = longint'(yaw_step_q);
    adx  = (dx < 0) ? -dx : dx;
    ady  = (dy < 0) ? -dy : dy;
    if (dy == 0) alpha = 0;
    else if (dx == 0) alpha = longint'(Q12_HALF_PI);
    else alpha = quadrant_angle(adx, ady);
    if (dx < 0) heading = (dy < 0) ? alpha - pi_q : pi_q - alpha;
    else heading = (dy < 0) ? -alpha : alpha;
    goal = heading;
    if (yaw - goal >= pi_q) goal = goal + two_pi_q;
    else if (yaw - goal <= -pi_q) goal = goal - two_pi_q;
    if (goal <= yaw) cmd = (yaw - goal > step) ? yaw - step : goal;
    else cmd = (goal - yaw > step) ? yaw + step : goal;
    near = (adx < longint'(near_thr_q)) && (ady < longint'(near_thr_q));
    if (near) cmd = yaw;
    if (cmd > 32767) cmd = 32767;
    if (cmd < -32768) cmd = -32768;
    r.cmd     = cmd[CMD_W-1:0];
    r.heading = heading[YAW_W-1:0];
    r.near    = near;
    return r;
  endfunction

  function automatic pose_t rand_pose();
    pose_t  p;
    longint off_x, off_y, t;
    int     shape, m, yaw_pick;
    bit     use_off;
    p.cx  = $urandom;
    p.cy  = $urandom;
    p.tx  = $urandom;
    p.ty  = $urandom;
    off_x = 0;
    off_y = 0;
    use_off = 1'b1;
    shape = $urandom_range(0, 9);
    case (shape)
      3, 4: begin
        m     = 1 << $urandom_range(0, 24);
        off_x = longint'($urandom_range(0, 2 * m)) - m;
        off_y = longint'($urandom_range(0, 2 * m)) - m;
      end
      5: begin
        use_off = 1'b0;
        if ($urandom_range(0, 1)) p.tx = p.cx;
        else p.ty = p.cy;
      end
      6: ;
      7: begin
        off_x = longint'(near_thr_q) + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1))
          off_y = longint'(near_thr_q) + longint'($urandom_range(0, 2)) - 1;
        else
          off_y = longint'($urandom_range(0, {1'b0, near_thr_q}));
        if ($urandom_range(0, 1)) begin
          t     = off_x;
          off_x = off_y;
          off_y = t;
        end
      end
      8, 9: begin
        m     = $urandom_range(1, 1 << 22);
        off_x = m;
        off_y = longint'(m) + longint'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          t     = off_x;
          off_x = off_y;
          off_y = t;
        end
      end
      default: use_off = 1'b0;
    endcase
    if (use_off) begin
      if ($urandom_range(0, 1)) off_x = -off_x;
      if ($urandom_range(0, 1)) off_y = -off_y;
      if (shape == 7) begin
        t    = -(off_x >>> 1);
        p.cx = t[POS_W-1:0];
        t    = -(off_y >>> 1);
        p.cy = t[POS_W-1:0];
      end
      t    = longint'($signed(p.cx)) + off_x;
      p.tx = t[POS_W-1:0];
      t    = longint'($signed(p.cy)) + off_y;
      p.ty = t[POS_W-1:0];
    end
    yaw_pick = $urandom_range(0, 19);
    if (yaw_pick < 3) t = longint'($urandom_range(0, 32767)) - 16384;
    else if (yaw_pick == 3) t = $urandom_range(0, 1) ? 12868 : -12868;
    else t = longint'($urandom_range(0, 25736)) - 12868;
    p.yaw = t[YAW_W-1:0];
    return p;
  endfunction

  task automatic add_row(input longint cx, input longint cy, input longint tx,
                         input longint ty, input longint yaw, input bit typed,
                         input longint cmd, input longint heading, input bit near);
    vec_t v;
    v.pose.cx      = cx[POS_W-1:0];
    v.pose.cy      = cy[POS_W-1:0];
    v.pose.tx      = tx[POS_W-1:0];
    v.pose.ty      = ty[POS_W-1:0];
    v.pose.yaw     = yaw[YAW_W-1:0];
    v.typed        = typed;
    v.want.cmd     = cmd[CMD_W-1:0];
    v.want.heading = heading[YAW_W-1:0];
    v.want.near    = near;
    directed_rows.insert(directed_rows.size(), v);
  endtask

  task automatic push_item(input pose_t p, input bit typed, input steer_t want);
    in_valid       <= 1'b1;
    in_current_x   <= p.cx;
    in_current_y   <= p.cy;
    in_target_x    <= p.tx;
    in_target_y    <= p.ty;
    in_current_yaw <= p.yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_steer.insert(expected_steer.size(), typed ? want : steer_for(p));
    @(negedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap        = gaps_on ? $urandom_range(0, 7) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_YAW_STEP:   yaw_step_q = data[STEP_W-1:0];
      REG_NEAR_THRESHOLD: near_thr_q = data[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_steer.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(16, 96);
    end
    stall_hold--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    steer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steer.size() == 0) begin
        $error("result transaction with nothing expected");
        n_errors++;
      end else begin
        want = expected_steer.pop_front();
        if (out_yaw_command !== want.cmd) begin
          $error("yaw_command: expected %0d, got %0d", want.cmd, out_yaw_command);
          n_errors++;
        end
        if (out_target_heading !== want.heading) begin
          $error("target_heading: expected %0d, got %0d", want.heading, out_target_heading);
          n_errors++;
        end
        if (out_near_target !== want.near) begin
          $error("near_target: expected %0d, got %0d", want.near, out_near_target);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("heading_slew_limiter_top_test: errors");
    $finish;
  end

  initial begin
    vec_t   row;
    steer_t blank;
    blank          = '0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_current_x   = '0;
    in_current_y   = '0;
    in_target_x    = '0;
    in_target_y    = '0;
    in_current_yaw = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_MAX_YAW_STEP;
    cfg_wdata      = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row(0, 0, 0, 0, 0, 1, 0, 0, 1);
    add_row(0, 0, 1000000, 0, 0, 1, 0, 0, 0);
    add_row(0, 0, -1000000, 0, 0, 1, -614, 12868, 0);
    add_row(0, 0, 0, 1000000, 0, 1, 614, 6434, 0);
    add_row(0, 0, 0, -1000000, 0, 1, -614, -6434, 0);
    add_row(POS_MIN, 0, POS_MAX, 0, 0, 1, 0, 0, 0);
    add_row(POS_MAX, 0, POS_MIN, 0, 12868, 1, 12868, 12868, 0);
    add_row(0, POS_MIN, 0, POS_MAX, 0, 1, 614, 6434, 0);
    add_row(0, POS_MAX, 0, POS_MIN, -6434, 1, -6434, -6434, 0);
    add_row(0, 0, -1000000, 0, -12868, 1, -12868, 12868, 0);
    add_row(0, 0, 1000000, 0, 12868, 1, 13482, 0, 0);
    add_row(0, 0, 1000000, 0, -12868, 1, -13482, 0, 0);
    add_row(0, 0, 19661, 0, 1000, 1, 386, 0, 0);
    add_row(0, 0, -19660, 0, 1000, 1, 1000, 12868, 1);
    add_row(0, 0, 19660, -19660, 1000, 0, 0, 0, 0);
    add_row(0, 0, 1000000, 0, 16383, 0, 0, 0, 0);
    add_row(0, 0, 1000000, 0, -16384, 0, 0, 0, 0);
    add_row(0, 0, 1000000, 1000000, 0, 0, 0, 0, 0);
    add_row(0, 0, -1000000, 1000000, 0, 0, 0, 0, 0);
    add_row(0, 0, -1000000, -1000000, 0, 0, 0, 0, 0);
    add_row(0, 0, 1000000, -1000000, 0, 0, 0, 0, 0);
    add_row(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 0, 0, 0, 0, 0);
    add_row(POS_MAX, POS_MAX, POS_MIN, POS_MIN, 12868, 0, 0, 0, 0);
    add_row(0, 0, 1, 2, 500, 0, 0, 0, 0);
    add_row(0, 0, 1, 2000000000, 0, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      pace_sender();
      push_item(row.pose, row.typed, row.want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_reg(REG_SPARE_A, $urandom);
          write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_MAX_YAW_STEP, 32'd0);
          write_reg(REG_NEAR_THRESHOLD, 32'd0);
        end
        2: begin
          write_reg(REG_MAX_YAW_STEP, 32'd12868);
          write_reg(REG_NEAR_THRESHOLD, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_MAX_YAW_STEP, 32'hFFFF_FFFF);
          write_reg(REG_NEAR_THRESHOLD, $urandom & 32'h00FF_FFFF);
        end
        4: begin
          write_reg(REG_MAX_YAW_STEP, 32'd1);
          write_reg(REG_NEAR_THRESHOLD, 32'd1);
        end
        5: begin
          write_reg(REG_MAX_YAW_STEP, $urandom_range(0, 12868));
          write_reg(REG_NEAR_THRESHOLD, $urandom_range(0, 1 << 20));
        end
        6: begin
          write_reg(REG_MAX_YAW_STEP, $urandom);
          write_reg(REG_NEAR_THRESHOLD, $urandom);
        end
        default: begin
          write_reg(REG_MAX_YAW_STEP, {{(CFG_DATA_W-STEP_W){1'b0}}, MAX_YAW_STEP_RST});
          write_reg(REG_NEAR_THRESHOLD, {{(CFG_DATA_W-THR_W){1'b0}}, NEAR_THRESHOLD_RST});
        end
      endcase
      cfg_valid <= 1'b0;
      gaps_on = (ph != 6);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 5 && k == ITEMS_PER_PHASE / 2) wait_drained();
        pace_sender();
        push_item(rand_pose(), 1'b0, blank);
      end
    end

    wait_drained();
    if (n_errors == 0 && expected_steer.size() == 0)
      $display("heading_slew_limiter_top_test: clean");
    else
      $display("heading_slew_limiter_top_test: errors");
    $finish;
  end

endmodule

@@ heading_slew_limiter_top.f @@
src/hsl_pkg.sv
src/hsl_front.sv
src/hsl_cordic_cell.sv
src/hsl_post.sv
src/heading_slew_limiter_top.sv
src/hsl_checker.sv
tb/heading_slew_limiter_top_test.sv
